// ===== rtl/core/uppf_pkg.sv =====
package uppf_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int BURST_LEN   = 8;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [3:0] {
    ST_HUNT1 = 4'd0,
    ST_HUNT2 = 4'd1,
    ST_CMD0  = 4'd2,
    ST_CMD1  = 4'd3,
    ST_CMD2  = 4'd4,
    ST_CMD3  = 4'd5,
    ST_LEN0  = 4'd6,
    ST_LEN1  = 4'd7,
    ST_DATA  = 4'd8,
    ST_FWD   = 4'd9,
    ST_TAIL  = 4'd10
  } parse_step_t;

  typedef enum logic [2:0] {
    K_FWD   = 3'd0,
    K_PAY   = 3'd1,
    K_GOOD  = 3'd2,
    K_BAD   = 3'd3,
    K_TOUT  = 3'd4,
    K_RESET = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    REG_HEADER_FIRST     = 3'd0,
    REG_HEADER_SECOND    = 3'd1,
    REG_OWN_MASK         = 3'd2,
    REG_OWN_VALUE        = 3'd3,
    REG_RESET_KIND_MASK  = 3'd4,
    REG_RESET_KIND_VALUE = 3'd5,
    REG_TIMEOUT_MS       = 3'd6
  } cfg_reg_t;

  // what the back end has to play out for one accepted item
  typedef enum logic [1:0] {
    OP_SINGLE    = 2'd0,
    OP_BURST     = 2'd1,
    OP_FWD_RESET = 2'd2
  } op_t;

  typedef struct packed {
    logic        action;
    logic [7:0]  rx_byte;
    logic [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [31:0] command_word;
    logic [15:0] packet_length;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [31:0] own_mask;
    logic [31:0] own_value;
    logic [31:0] reset_kind_mask;
    logic [31:0] reset_kind_value;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    kind_t       kind;
    logic [7:0]  byte_val;
    logic [31:0] cmd;
    logic [15:0] len;
  } desc_t;

endpackage

// ===== rtl/core/uart_packet_parse_forward.sv =====
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    in_data   (uppf_pkg::in_item_t)
// out      output     out_valid / out_ready  out_data  (uppf_pkg::out_item_t)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one input transaction is taken per cycle while the descriptor queue has room
// each result is one output item; a forwarded header is replayed as 8 items, a
// forwarded last byte with reset request as 2, everything else as 1
// the back end sequencer sets the output rate, the queue (QUEUE_DEPTH entries)
// absorbs header bursts; ticks under the timeout use no queue slot
// rst is synchronous: parser state and queue clear, registers take defaults
// cfg_ready is always high
module uart_packet_parse_forward #(
  parameter int QUEUE_DEPTH = uppf_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  uppf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output uppf_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import uppf_pkg::*;

  cfg_t  cfg;
  logic  take;
  logic  push;
  desc_t push_desc;
  logic  q_valid;
  logic  q_ready;
  desc_t q_head;
  logic  pop;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_ready;
  assign take      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{header_first: '0, header_second: '0, own_mask: '0, own_value: '0,
               reset_kind_mask: '0, reset_kind_value: '0, timeout_ms: TIMEOUT_RESET};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER_FIRST:     cfg.header_first     <= cfg_data[7:0];
        REG_HEADER_SECOND:    cfg.header_second    <= cfg_data[7:0];
        REG_OWN_MASK:         cfg.own_mask         <= cfg_data;
        REG_OWN_VALUE:        cfg.own_value        <= cfg_data;
        REG_RESET_KIND_MASK:  cfg.reset_kind_mask  <= cfg_data;
        REG_RESET_KIND_VALUE: cfg.reset_kind_value <= cfg_data;
        REG_TIMEOUT_MS:       cfg.timeout_ms       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  uppf_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (take),
    .item (in_data),
    .push (push),
    .desc (push_desc)
  );

  uppf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_desc),
    .pop       (pop),
    .valid     (q_valid),
    .ready     (q_ready),
    .head      (q_head)
  );

  uppf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // queue is empty right after reset
  a_ready_after_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  a_timeout_cleared: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == K_TOUT |->
      out_data.command_word == 32'd0 && out_data.packet_length == 16'd0 && out_data.last)
    else $error("timeout result carries stale packet fields");

  a_reset_req_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == K_RESET |-> out_data.last && out_data.out_byte == 8'd0)
    else $error("reset request not the final result");

  // nothing queued and last result taken: output must go idle
  a_idle_when_drained: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last && !q_valid |=> !out_valid)
    else $error("output valid without a queued transaction");

endmodule

// ===== rtl/core/uppf_front.sv =====
module uppf_front (
  input  logic             clk,
  input  logic             rst,
  input  uppf_pkg::cfg_t   cfg,
  input  logic             take,
  input  uppf_pkg::in_item_t item,
  output logic             push,
  output uppf_pkg::desc_t  desc
);
  import uppf_pkg::*;

  parse_step_t step, step_next;
  logic [16:0] idle_time, idle_time_next;
  logic [31:0] command_reg, command_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [16:0] byte_count, byte_count_next;
  logic [7:0]  checksum_sum, checksum_sum_next;

  logic [16:0] idle_sum;
  logic [16:0] count_inc;
  logic [7:0]  b;
  logic [7:0]  sum_inv;

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_HUNT1;
      idle_time    <= '0;
      command_reg  <= '0;
      length_reg   <= '0;
      byte_count   <= '0;
      checksum_sum <= '0;
    end else begin
      step         <= step_next;
      idle_time    <= idle_time_next;
      command_reg  <= command_reg_next;
      length_reg   <= length_reg_next;
      byte_count   <= byte_count_next;
      checksum_sum <= checksum_sum_next;
    end
  end

  always_comb begin
    b         = item.rx_byte;
    idle_sum  = idle_time + {1'b0, item.elapsed_ms};
    count_inc = byte_count + 17'd1;
    sum_inv   = ~checksum_sum;

    step_next         = step;
    idle_time_next    = idle_time;
    command_reg_next  = command_reg;
    length_reg_next   = length_reg;
    byte_count_next   = byte_count;
    checksum_sum_next = checksum_sum;
    push              = 1'b0;
    desc.op           = OP_SINGLE;
    desc.kind         = K_FWD;
    desc.byte_val     = '0;

    if (take) begin
      if (item.action) begin
        idle_time_next = idle_sum;
        if (idle_sum > {1'b0, cfg.timeout_ms}) begin
          step_next         = ST_HUNT1;
          idle_time_next    = '0;
          command_reg_next  = '0;
          length_reg_next   = '0;
          byte_count_next   = '0;
          checksum_sum_next = '0;
          push              = 1'b1;
          desc.kind         = K_TOUT;
        end
      end else begin
        idle_time_next = '0;
        case (step)
          ST_HUNT1: begin
            if (b == cfg.header_first) step_next = ST_HUNT2;
          end
          ST_HUNT2: begin
            // a repeated first byte keeps waiting for the second
            if (b == cfg.header_second) step_next = ST_CMD0;
            else if (b != cfg.header_first) step_next = ST_HUNT1;
          end
          ST_CMD0: begin
            byte_count_next   = '0;
            command_reg_next  = {24'd0, b};
            checksum_sum_next = b;
            step_next         = ST_CMD1;
          end
          ST_CMD1: begin
            command_reg_next  = command_reg | {16'd0, b, 8'd0};
            checksum_sum_next = checksum_sum + b;
            step_next         = ST_CMD2;
          end
          ST_CMD2: begin
            command_reg_next  = command_reg | {8'd0, b, 16'd0};
            checksum_sum_next = checksum_sum + b;
            step_next         = ST_CMD3;
          end
          ST_CMD3: begin
            command_reg_next  = command_reg | {b, 24'd0};
            checksum_sum_next = checksum_sum + b;
            step_next         = ST_LEN0;
          end
          ST_LEN0: begin
            length_reg_next   = {8'd0, b};
            checksum_sum_next = checksum_sum + b;
            step_next         = ST_LEN1;
          end
          ST_LEN1: begin
            length_reg_next   = length_reg | {b, 8'd0};
            checksum_sum_next = checksum_sum + b;
            if ((command_reg & cfg.own_mask) != cfg.own_value) begin
              push      = 1'b1;
              desc.op   = OP_BURST;
              step_next = ST_FWD;
            end else if (length_reg_next == 16'd0) begin
              step_next = ST_TAIL;
            end else begin
              step_next = ST_DATA;
            end
          end
          ST_DATA: begin
            push              = 1'b1;
            desc.kind         = K_PAY;
            desc.byte_val     = b;
            byte_count_next   = count_inc;
            checksum_sum_next = checksum_sum + b;
            if (count_inc >= {1'b0, length_reg}) step_next = ST_TAIL;
          end
          ST_FWD: begin
            push              = 1'b1;
            desc.byte_val     = b;
            byte_count_next   = count_inc;
            checksum_sum_next = checksum_sum + b;
            // payload plus the checksum byte
            if (count_inc >= {1'b0, length_reg} + 17'd1) begin
              if ((command_reg & cfg.reset_kind_mask) == cfg.reset_kind_value) begin
                desc.op = OP_FWD_RESET;
              end
              step_next = ST_HUNT1;
            end
          end
          ST_TAIL: begin
            checksum_sum_next = sum_inv;
            push              = 1'b1;
            desc.kind         = (sum_inv == b) ? K_GOOD : K_BAD;
            step_next         = ST_HUNT1;
          end
          default: begin
            step_next = ST_HUNT1;
          end
        endcase
      end
    end

    desc.cmd = command_reg_next;
    desc.len = length_reg_next;
  end

endmodule

// ===== rtl/core/uppf_queue.sv =====
module uppf_queue #(
  parameter int DEPTH = uppf_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  uppf_pkg::desc_t push_data,
  input  logic            pop,
  output logic            valid,
  output logic            ready,
  output uppf_pkg::desc_t head
);
  import uppf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign valid   = (count != '0);
  assign ready   = (count != CNT_W'(DEPTH));
  assign head    = entries[rd_ptr];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (do_push && !do_pop)      count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

// ===== rtl/core/uppf_back.sv =====
module uppf_back (
  input  logic             clk,
  input  logic             rst,
  input  uppf_pkg::cfg_t   cfg,
  input  logic             q_valid,
  input  uppf_pkg::desc_t  q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output uppf_pkg::out_item_t out_data
);
  import uppf_pkg::*;

  localparam int STEP_W = $clog2(BURST_LEN);

  logic              busy;
  logic [STEP_W-1:0] step;
  desc_t             cur;
  logic              is_last;
  logic              fire;

  assign out_valid = busy;
  assign fire      = busy && out_ready;
  assign pop       = q_valid && (!busy || (out_ready && is_last));

  always_comb begin
    out_data.kind          = cur.kind;
    out_data.out_byte      = cur.byte_val;
    out_data.command_word  = cur.cmd;
    out_data.packet_length = cur.len;
    is_last                = 1'b1;
    case (cur.op)
      OP_SINGLE: begin
        is_last = 1'b1;
      end
      OP_BURST: begin
        // header, command and length replayed little-endian
        out_data.kind = K_FWD;
        is_last       = (step == STEP_W'(BURST_LEN - 1));
        case (step)
          3'd0:    out_data.out_byte = cfg.header_first;
          3'd1:    out_data.out_byte = cfg.header_second;
          3'd2:    out_data.out_byte = cur.cmd[7:0];
          3'd3:    out_data.out_byte = cur.cmd[15:8];
          3'd4:    out_data.out_byte = cur.cmd[23:16];
          3'd5:    out_data.out_byte = cur.cmd[31:24];
          3'd6:    out_data.out_byte = cur.len[7:0];
          default: out_data.out_byte = cur.len[15:8];
        endcase
      end
      OP_FWD_RESET: begin
        if (step == '0) begin
          out_data.kind = K_FWD;
          is_last       = 1'b0;
        end else begin
          out_data.kind     = K_RESET;
          out_data.out_byte = '0;
          is_last           = 1'b1;
        end
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
    out_data.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      step <= '0;
    end else if (fire) begin
      if (is_last) busy <= 1'b0;
      else step <= step + STEP_W'(1);
    end
  end

endmodule
